/* rtl/crff_pkg.sv */
// ----------------------------------------------------------------------------
// crff_pkg
// Shared constants, codes and types of the clipped rectangle fill framebuffer.
// ----------------------------------------------------------------------------
package crff_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int NUM_PIXELS    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(NUM_PIXELS);
    localparam int X_W           = $clog2(SCREEN_WIDTH);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT);
    // holds pos plus span (17 bits of magnitude) with sign
    localparam int COORD_W       = 18;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_FILL_RECT = 3'd1;
    localparam logic [2:0] CMD_HLINE     = 3'd2;
    localparam logic [2:0] CMD_VLINE     = 3'd3;
    localparam logic [2:0] CMD_SWAP      = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
    localparam logic [2:0] REG_CLIP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CLIP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_DOUBLE_BUF  = 3'd4;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        span_w;
        logic [15:0]        span_h;
        logic [15:0]        fill_color;
        logic               read_front;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        wrote_pixels;
    } t_out_item;

    typedef struct packed {
        logic [8:0] clip_left;
        logic [7:0] clip_top;
        logic [8:0] clip_width;
        logic [7:0] clip_height;
        logic       double_buffer_on;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic setup;
        logic check;
        logic load_full;
        logic fill_step;
        logic fill_both;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] code;
        logic       empty;
        logic       last;
    } t_dp_status;

endpackage

/* rtl/crff_regs.sv */
// ----------------------------------------------------------------------------
// crff_regs
// Clip rectangle and buffering registers behind an APB-style port.
// ----------------------------------------------------------------------------
module crff_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crff_pkg::PADDR_W-1:0]  paddr,
    input  logic [crff_pkg::PDATA_W-1:0]  pwdata,
    output logic [crff_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output crff_pkg::t_cfg                o_cfg
);

    crff_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[crff_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left        <= 9'd0;
            r_cfg.clip_top         <= 8'd0;
            r_cfg.clip_width       <= 9'd320;
            r_cfg.clip_height      <= 8'd240;
            r_cfg.double_buffer_on <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                crff_pkg::REG_CLIP_LEFT:   r_cfg.clip_left        <= pwdata[8:0];
                crff_pkg::REG_CLIP_TOP:    r_cfg.clip_top         <= pwdata[7:0];
                crff_pkg::REG_CLIP_WIDTH:  r_cfg.clip_width       <= pwdata[8:0];
                crff_pkg::REG_CLIP_HEIGHT: r_cfg.clip_height      <= pwdata[7:0];
                crff_pkg::REG_DOUBLE_BUF:  r_cfg.double_buffer_on <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            crff_pkg::REG_CLIP_LEFT:   prdata = {23'd0, r_cfg.clip_left};
            crff_pkg::REG_CLIP_TOP:    prdata = {24'd0, r_cfg.clip_top};
            crff_pkg::REG_CLIP_WIDTH:  prdata = {23'd0, r_cfg.clip_width};
            crff_pkg::REG_CLIP_HEIGHT: prdata = {24'd0, r_cfg.clip_height};
            crff_pkg::REG_DOUBLE_BUF:  prdata = {31'd0, r_cfg.double_buffer_on};
            default:                   prdata = '0;
        endcase
    end

endmodule

/* rtl/crff_ctrl.sv */
// ----------------------------------------------------------------------------
// crff_ctrl
// Sequencer: wipe after reset, then per request clip, fill or read, respond.
// ----------------------------------------------------------------------------
module crff_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    input  crff_pkg::t_dp_status i_status,
    output crff_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [8:0] {
        ST_INIT   = 9'b0_0000_0001,
        ST_WIPE   = 9'b0_0000_0010,
        ST_IDLE   = 9'b0_0000_0100,
        ST_SETUP  = 9'b0_0000_1000,
        ST_CHECK  = 9'b0_0001_0000,
        ST_FILL   = 9'b0_0010_0000,
        ST_RD     = 9'b0_0100_0000,
        ST_RDWAIT = 9'b0_1000_0000,
        ST_FINISH = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.load_full = 1'b1;
                n_state         = ST_WIPE;
            end
            ST_WIPE: begin
                o_cmd.fill_step = 1'b1;
                o_cmd.fill_both = 1'b1;
                if (i_status.last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                unique case (i_status.code) inside
                    crff_pkg::CMD_CLEAR, crff_pkg::CMD_FILL_RECT,
                    crff_pkg::CMD_HLINE, crff_pkg::CMD_VLINE: begin
                        n_state = i_status.empty ? ST_FINISH : ST_FILL;
                    end
                    crff_pkg::CMD_READ: n_state = ST_RD;
                    default:            n_state = ST_FINISH;
                endcase
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.last) n_state = ST_FINISH;
            end
            ST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ST_RDWAIT;
            end
            ST_RDWAIT: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_resp_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("response raised outside finish");
    a_resp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled response dropped");
    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && i_status.last) |=> (r_state == ST_FINISH))
        else $error("fill did not finish on its last pixel");
    a_wipe_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WIPE) |-> !r_out_valid)
        else $error("response during power-up wipe");
`endif

endmodule

/* rtl/crff_dpath.sv */
// ----------------------------------------------------------------------------
// crff_dpath
// Clip arithmetic, pixel scan counters and the two frame memories.
// ----------------------------------------------------------------------------
module crff_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crff_pkg::t_cfg        i_cfg,
    input  crff_pkg::t_in_item    i_in_data,
    input  crff_pkg::t_dp_cmd     i_cmd,
    output crff_pkg::t_dp_status  o_status,
    output crff_pkg::t_out_item   o_out_data
);

    logic [15:0] mem0 [crff_pkg::NUM_PIXELS];
    logic [15:0] mem1 [crff_pkg::NUM_PIXELS];

    // latched request
    logic [2:0]         r_code;
    logic signed [15:0] r_px, r_py;
    logic [15:0]        r_w, r_h;
    logic [15:0]        r_color;
    logic               r_rfront;

    // clipped region, wide
    crff_pkg::t_coord r_x0s, r_x1s, r_y0s, r_y1s;
    crff_pkg::t_coord n_x0s, n_x1s, n_y0s, n_y1s;
    logic             r_hit, n_hit;

    // scan
    logic [crff_pkg::X_W-1:0]    r_col, r_x0, r_x1m1;
    logic [crff_pkg::Y_W-1:0]    r_row, r_y1m1;
    logic [crff_pkg::ADDR_W-1:0] r_row_base, addr;
    crff_pkg::t_coord            x1m1, y1m1;

    logic        r_front_is_one;
    logic [15:0] r_rd0, r_rd1;
    logic [15:0] r_res_data;
    logic        r_res_wrote;
    crff_pkg::t_out_item r_out;

    crff_pkg::t_coord px_c, py_c, w_c, h_c, xe_c, ye_c;
    crff_pkg::t_coord cl_c, cr_c, ct_c, cb_c, sw_c, sh_c;
    logic empty, col_last, row_last, we0, we1, rd_en, sel_one;

    assign sw_c = crff_pkg::t_coord'(crff_pkg::SCREEN_WIDTH);
    assign sh_c = crff_pkg::t_coord'(crff_pkg::SCREEN_HEIGHT);

    always_comb begin
        // clip edges saturated to the screen
        cl_c = crff_pkg::t_coord'(i_cfg.clip_left);
        cr_c = crff_pkg::t_coord'({1'b0, i_cfg.clip_left} + {1'b0, i_cfg.clip_width});
        ct_c = crff_pkg::t_coord'(i_cfg.clip_top);
        cb_c = crff_pkg::t_coord'({1'b0, i_cfg.clip_top} + {1'b0, i_cfg.clip_height});
        if (cl_c > sw_c) cl_c = sw_c;
        if (cr_c > sw_c) cr_c = sw_c;
        if (ct_c > sh_c) ct_c = sh_c;
        if (cb_c > sh_c) cb_c = sh_c;

        px_c = crff_pkg::t_coord'(r_px);
        py_c = crff_pkg::t_coord'(r_py);
        w_c  = crff_pkg::t_coord'(r_w);
        h_c  = crff_pkg::t_coord'(r_h);
        if (r_code == crff_pkg::CMD_HLINE) h_c = crff_pkg::t_coord'(1);
        if (r_code == crff_pkg::CMD_VLINE) w_c = crff_pkg::t_coord'(1);
        xe_c = px_c + w_c;
        ye_c = py_c + h_c;

        n_x0s = (px_c > cl_c) ? px_c : cl_c;
        n_x1s = (xe_c < cr_c) ? xe_c : cr_c;
        n_y0s = (py_c > ct_c) ? py_c : ct_c;
        n_y1s = (ye_c < cb_c) ? ye_c : cb_c;
        if (r_code == crff_pkg::CMD_CLEAR) begin
            n_x0s = '0;
            n_x1s = sw_c;
            n_y0s = '0;
            n_y1s = sh_c;
        end else if (r_code == crff_pkg::CMD_READ) begin
            n_x0s = px_c;
            n_y0s = py_c;
        end
        n_hit = (px_c >= 0) && (px_c < sw_c) && (py_c >= 0) && (py_c < sh_c);
    end

    assign empty    = (r_x0s >= r_x1s) || (r_y0s >= r_y1s);
    assign x1m1     = r_x1s - crff_pkg::t_coord'(1);
    assign y1m1     = r_y1s - crff_pkg::t_coord'(1);
    assign col_last = (r_col == r_x1m1);
    assign row_last = (r_row == r_y1m1);
    assign addr     = r_row_base + crff_pkg::ADDR_W'(r_col);

    assign o_status.code  = r_code;
    assign o_status.empty = empty;
    assign o_status.last  = col_last && row_last;

    // back buffer is frame zero while the front is frame one
    assign we0     = i_cmd.fill_step && (i_cmd.fill_both || r_front_is_one);
    assign we1     = i_cmd.fill_step && (i_cmd.fill_both || !r_front_is_one);
    assign rd_en   = i_cmd.rd_issue && r_hit;
    assign sel_one = (r_rfront && i_cfg.double_buffer_on) ? r_front_is_one
                                                          : !r_front_is_one;

    always_ff @(posedge i_clk) begin
        if (we0) mem0[addr] <= r_color;
        if (rd_en) r_rd0 <= mem0[addr];
    end

    always_ff @(posedge i_clk) begin
        if (we1) mem1[addr] <= r_color;
        if (rd_en) r_rd1 <= mem1[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_is_one <= 1'b1;
        end else if (i_cmd.check && r_code == crff_pkg::CMD_SWAP
                     && i_cfg.double_buffer_on) begin
            r_front_is_one <= !r_front_is_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_code   <= i_in_data.command;
            r_px     <= i_in_data.pos_x;
            r_py     <= i_in_data.pos_y;
            r_w      <= i_in_data.span_w;
            r_h      <= i_in_data.span_h;
            r_color  <= i_in_data.fill_color;
            r_rfront <= i_in_data.read_front;
        end else if (i_cmd.load_full) begin
            r_color  <= '0;
        end

        if (i_cmd.setup) begin
            r_x0s <= n_x0s;
            r_x1s <= n_x1s;
            r_y0s <= n_y0s;
            r_y1s <= n_y1s;
            r_hit <= n_hit;
        end

        if (i_cmd.load_full) begin
            r_col      <= '0;
            r_x0       <= '0;
            r_x1m1     <= crff_pkg::X_W'(crff_pkg::SCREEN_WIDTH - 1);
            r_row      <= '0;
            r_y1m1     <= crff_pkg::Y_W'(crff_pkg::SCREEN_HEIGHT - 1);
            r_row_base <= '0;
        end else if (i_cmd.check) begin
            r_col      <= r_x0s[crff_pkg::X_W-1:0];
            r_x0       <= r_x0s[crff_pkg::X_W-1:0];
            r_x1m1     <= x1m1[crff_pkg::X_W-1:0];
            r_row      <= r_y0s[crff_pkg::Y_W-1:0];
            r_y1m1     <= y1m1[crff_pkg::Y_W-1:0];
            r_row_base <= crff_pkg::ADDR_W'(r_y0s[crff_pkg::Y_W-1:0]
                                            * crff_pkg::SCREEN_WIDTH);
        end else if (i_cmd.fill_step) begin
            // advance along the row, wrap to the next row at the right edge
            if (col_last) begin
                r_col      <= r_x0;
                r_row      <= r_row + 1'b1;
                r_row_base <= r_row_base + crff_pkg::ADDR_W'(crff_pkg::SCREEN_WIDTH);
            end else begin
                r_col <= r_col + 1'b1;
            end
        end

        if (i_cmd.check) begin
            r_res_data <= '0;
            case (r_code) inside
                crff_pkg::CMD_CLEAR:  r_res_wrote <= 1'b1;
                crff_pkg::CMD_FILL_RECT, crff_pkg::CMD_HLINE,
                crff_pkg::CMD_VLINE:  r_res_wrote <= !empty;
                crff_pkg::CMD_SWAP:   r_res_wrote <= i_cfg.double_buffer_on;
                default:              r_res_wrote <= 1'b0;
            endcase
        end else if (i_cmd.rd_capture) begin
            r_res_data <= r_hit ? (sel_one ? r_rd1 : r_rd0) : 16'd0;
        end

        if (i_cmd.out_load) begin
            r_out.read_data    <= r_res_data;
            r_out.wrote_pixels <= r_res_wrote;
        end
    end

    assign o_out_data = r_out;

endmodule

/* rtl/clipped_rect_fill_framebuffer.sv */
// ----------------------------------------------------------------------------
// clipped_rect_fill_framebuffer
// Double-buffered RGB565 frame store with clipped rectangle and line fills.
//
//   channel   direction  handshake                payload
//   request   in         i_in_valid / o_in_stall  i_in_data  (t_in_item)
//   response  out        o_out_valid / i_out_stall o_out_data (t_out_item)
//   config    in         psel, penable, pwrite    paddr, pwdata, prdata
//
// Fill commands write one pixel per cycle through the frame memory write
// port. Each request is latched, clipped in setup, checked, then filled or
// read, and finishes by loading the output register. Swap, unused codes and
// fully clipped fills go straight from check to finish. After reset both
// frames are wiped in parallel, with requests stalled. A response waits in
// its output register while the request side takes the next command; the next response waits until it is taken.
// ----------------------------------------------------------------------------
module clipped_rect_fill_framebuffer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  crff_pkg::t_in_item            i_in_data,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output crff_pkg::t_out_item           o_out_data,
    input  logic                          i_out_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crff_pkg::PADDR_W-1:0]  paddr,
    input  logic [crff_pkg::PDATA_W-1:0]  pwdata,
    output logic [crff_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    crff_pkg::t_cfg       cfg;
    crff_pkg::t_dp_cmd    dp_cmd;
    crff_pkg::t_dp_status dp_status;

    crff_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    crff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    crff_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .o_out_data (o_out_data)
    );

endmodule

/* bench/tb_clipped_rect_fill_framebuffer.sv */
// ----------------------------------------------------------------------------
// tb_clipped_rect_fill_framebuffer
// Drives fill, line, clear, swap and pixel-read requests into the frame store
// and checks every response against a pixel-accurate model of both frames.
// The clip rectangle and buffering mode are reprogrammed over the APB port
// between phases; sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_clipped_rect_fill_framebuffer;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int QUIET_LIMIT = 250000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          req_valid = 1'b0;
    crff_pkg::t_in_item            req_data = '0;
    logic                          in_stall;
    logic                          out_valid;
    crff_pkg::t_out_item           out_data;
    logic                          out_stall = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [crff_pkg::PADDR_W-1:0]  paddr = '0;
    logic [crff_pkg::PDATA_W-1:0]  pwdata = '0;
    logic [crff_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    // model of the frame store
    bit [15:0]       pixels [2][crff_pkg::NUM_PIXELS];
    bit              front_one = 1'b1;
    crff_pkg::t_cfg  clip_cfg = '{clip_left: 9'd0, clip_top: 8'd0, clip_width: 9'd320,
                                  clip_height: 8'd240, double_buffer_on: 1'b1};

    crff_pkg::t_in_item  cmd_queue[$];
    crff_pkg::t_out_item due_responses[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int n_accepted = 0;
    int n_fills = 0;
    int n_reads = 0;
    int n_swaps = 0;
    int n_clears = 0;
    int n_checked = 0;
    int quiet_cycles = 0;
    int last_x = 0;
    int last_y = 0;

    clipped_rect_fill_framebuffer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .i_in_data   (req_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 clk = ~clk;

    function automatic int drawn_frame();
        return front_one ? 0 : 1;
    endfunction

    function automatic int shown_frame();
        if (!clip_cfg.double_buffer_on) return drawn_frame();
        return front_one ? 1 : 0;
    endfunction

    function automatic bit fill_clipped(input int x, input int y, input int w, input int h,
                                        input logic [15:0] color);
        int cl, cr, ct, cb, x0, x1, y0, y1, r, c, f;
        cl = int'(clip_cfg.clip_left);
        cr = cl + int'(clip_cfg.clip_width);
        ct = int'(clip_cfg.clip_top);
        cb = ct + int'(clip_cfg.clip_height);
        // saturate each clip edge to the screen
        if (cl > crff_pkg::SCREEN_WIDTH)  cl = crff_pkg::SCREEN_WIDTH;
        if (cr > crff_pkg::SCREEN_WIDTH)  cr = crff_pkg::SCREEN_WIDTH;
        if (ct > crff_pkg::SCREEN_HEIGHT) ct = crff_pkg::SCREEN_HEIGHT;
        if (cb > crff_pkg::SCREEN_HEIGHT) cb = crff_pkg::SCREEN_HEIGHT;
        x0 = (x > cl) ? x : cl;
        x1 = (x + w < cr) ? x + w : cr;
        y0 = (y > ct) ? y : ct;
        y1 = (y + h < cb) ? y + h : cb;
        f = drawn_frame();
        if (x0 >= x1 || y0 >= y1) return 1'b0;
        for (r = y0; r < y1; r++)
            for (c = x0; c < x1; c++)
                pixels[f][r * crff_pkg::SCREEN_WIDTH + c] = color;
        return 1'b1;
    endfunction

    function automatic crff_pkg::t_out_item apply_command(input crff_pkg::t_in_item req);
        crff_pkg::t_out_item res;
        int x, y, i, f;
        res = '0;
        x = int'(req.pos_x);
        y = int'(req.pos_y);
        case (req.command)
            crff_pkg::CMD_CLEAR: begin
                f = drawn_frame();
                for (i = 0; i < crff_pkg::NUM_PIXELS; i++) pixels[f][i] = req.fill_color;
                res.wrote_pixels = 1'b1;
            end
            crff_pkg::CMD_FILL_RECT: res.wrote_pixels =
                fill_clipped(x, y, int'(req.span_w), int'(req.span_h), req.fill_color);
            crff_pkg::CMD_HLINE: res.wrote_pixels =
                fill_clipped(x, y, int'(req.span_w), 1, req.fill_color);
            crff_pkg::CMD_VLINE: res.wrote_pixels =
                fill_clipped(x, y, 1, int'(req.span_h), req.fill_color);
            crff_pkg::CMD_SWAP: begin
                if (clip_cfg.double_buffer_on) begin
                    front_one = ~front_one;
                    res.wrote_pixels = 1'b1;
                end
            end
            crff_pkg::CMD_READ: begin
                if (x >= 0 && x < crff_pkg::SCREEN_WIDTH
                    && y >= 0 && y < crff_pkg::SCREEN_HEIGHT) begin
                    f = req.read_front ? shown_frame() : drawn_frame();
                    res.read_data = pixels[f][y * crff_pkg::SCREEN_WIDTH + x];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic crff_pkg::t_in_item make_req(input logic [2:0] cmd, input int x,
                                                    input int y, input int w, input int h,
                                                    input int color, input bit front);
        crff_pkg::t_in_item r;
        r.command    = cmd;
        r.pos_x      = 16'(x);
        r.pos_y      = 16'(y);
        r.span_w     = 16'(w);
        r.span_h     = 16'(h);
        r.fill_color = 16'(color);
        r.read_front = front;
        return r;
    endfunction

    function automatic crff_pkg::t_in_item random_req();
        crff_pkg::t_in_item r;
        int pick;
        bit far;
        pick = int'($urandom_range(99));
        far = ($urandom_range(99) < 15);
        r.fill_color = 16'($urandom);
        r.read_front = 1'($urandom);
        r.span_w = 16'($urandom);
        r.span_h = 16'($urandom);
        if (far) begin
            r.pos_x = 16'($urandom);
            r.pos_y = 16'($urandom);
        end else begin
            r.pos_x = 16'(int'($urandom_range(360)) - 20);
            r.pos_y = 16'(int'($urandom_range(280)) - 20);
        end
        if (pick < 30) begin
            r.command = crff_pkg::CMD_FILL_RECT;
            if (far) begin
                // start past the right or bottom edge: large spans, nothing drawn
                if ($urandom_range(1))
                    r.pos_x = 16'($urandom_range(32767, crff_pkg::SCREEN_WIDTH));
                else
                    r.pos_y = 16'($urandom_range(32767, crff_pkg::SCREEN_HEIGHT));
            end else begin
                r.span_w = 16'($urandom_range(24));
                r.span_h = 16'($urandom_range(24));
            end
        end else if (pick < 45) begin
            r.command = crff_pkg::CMD_HLINE;
            if ($urandom_range(99) < 70) r.span_w = 16'($urandom_range(64));
        end else if (pick < 60) begin
            r.command = crff_pkg::CMD_VLINE;
            if ($urandom_range(99) < 70) r.span_h = 16'($urandom_range(64));
        end else if (pick < 88) begin
            r.command = crff_pkg::CMD_READ;
            // aim half the near reads at the latest drawn region
            if (!far && $urandom_range(1)) begin
                r.pos_x = 16'(last_x + int'($urandom_range(3)));
                r.pos_y = 16'(last_y + int'($urandom_range(3)));
            end
        end else if (pick < 95) begin
            r.command = crff_pkg::CMD_SWAP;
        end else begin
            r.command = $urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7;
        end
        if (r.command inside {crff_pkg::CMD_FILL_RECT, crff_pkg::CMD_HLINE,
                              crff_pkg::CMD_VLINE}) begin
            last_x = int'(r.pos_x);
            last_y = int'(r.pos_y);
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else begin
            if (req_valid && !in_stall) begin
                due_responses.push_back(apply_command(req_data));
                n_accepted++;
                case (req_data.command)
                    crff_pkg::CMD_CLEAR: n_clears++;
                    crff_pkg::CMD_FILL_RECT, crff_pkg::CMD_HLINE,
                    crff_pkg::CMD_VLINE: n_fills++;
                    crff_pkg::CMD_SWAP: n_swaps++;
                    crff_pkg::CMD_READ: n_reads++;
                    default: ;
                endcase
            end
            if (!req_valid || !in_stall) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_data  <= cmd_queue.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk) begin
        crff_pkg::t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_responses.size() == 0) begin
                    $display("%0t: expected no response, got read_data=%h wrote_pixels=%b",
                             $time, out_data.read_data, out_data.wrote_pixels);
                    mismatches++;
                end else begin
                    want = due_responses.pop_front();
                    n_checked++;
                    if (out_data.read_data !== want.read_data) begin
                        $display("%0t: read_data expected %h got %h",
                                 $time, want.read_data, out_data.read_data);
                        mismatches++;
                    end
                    if (out_data.wrote_pixels !== want.wrote_pixels) begin
                        $display("%0t: wrote_pixels expected %b got %b",
                                 $time, want.wrote_pixels, out_data.wrote_pixels);
                        mismatches++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: give up when neither channel moves for too long
    always @(posedge clk) begin
        if ((req_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_clipped_rect_fill_framebuffer NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        @(negedge clk);
        while (cmd_queue.size() != 0 || req_valid || due_responses.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            crff_pkg::REG_CLIP_LEFT:   clip_cfg.clip_left        = val[8:0];
            crff_pkg::REG_CLIP_TOP:    clip_cfg.clip_top         = val[7:0];
            crff_pkg::REG_CLIP_WIDTH:  clip_cfg.clip_width       = val[8:0];
            crff_pkg::REG_CLIP_HEIGHT: clip_cfg.clip_height      = val[7:0];
            crff_pkg::REG_DOUBLE_BUF:  clip_cfg.double_buffer_on = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input int left, input int top, input int width, input int height,
                             input bit dbuf);
        write_reg(crff_pkg::REG_CLIP_LEFT, 32'(left));
        write_reg(crff_pkg::REG_CLIP_TOP, 32'(top));
        write_reg(crff_pkg::REG_CLIP_WIDTH, 32'(width));
        write_reg(crff_pkg::REG_CLIP_HEIGHT, 32'(height));
        write_reg(crff_pkg::REG_DOUBLE_BUF, 32'(dbuf));
    endtask

    task automatic next_phase();
        wait_drained();
        // let the engine settle before touching the registers
        repeat (8) @(posedge clk);
    endtask

    task automatic random_phase(input int n, input int idle_pct, input int stall_pct,
                                input bit with_clear, input bit with_big_fill,
                                input bit with_pause);
        int i;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < n; i++) begin
            // hold further requests until every response is back
            if (with_pause && i == n / 2) wait_drained();
            if (with_clear && i == n / 3)
                cmd_queue.push_back(make_req(crff_pkg::CMD_CLEAR, 0, 0, 0, 0,
                                             int'($urandom), 1'b0));
            else if (with_big_fill && i == n / 4)
                cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, -32768, -32768,
                                             65535, 65535, int'($urandom), 1'b0));
            else
                cmd_queue.push_back(random_req());
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset defaults, no idling
        configure(0, 0, 320, 240, 1'b1);
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b1));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 319, 239, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_CLEAR, 0, 0, 0, 0, 'hFFFF, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 0, 0, 0, 0, 0, 1'b1));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, 10, 20, 5, 3, 'h1234, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 14, 22, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, 10, 20, 0, 7, 'h4321, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, -5, -5, 10, 10, 'h0F0F, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, 320, 0, 10, 10, 'h1111, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, 0, 240, 10, 10, 'h2222, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, 32767, 32767, 65535, 65535,
                                     'h3333, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_HLINE, 300, 100, 100, 0, 'hF800, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_VLINE, 5, 230, 0, 50, 'h07E0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_SWAP, 0, 0, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 310, 100, 0, 0, 0, 1'b1));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 310, 100, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, -1, 0, 0, 0, 0, 1'b1));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 0, 240, 0, 0, 0, 1'b1));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, -32768, -32768, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(CMD_SPARE_6, 1, 1, 1, 1, 'hFFFF, 1'b1));
        cmd_queue.push_back(make_req(CMD_SPARE_7, 2, 2, 2, 2, 'hFFFF, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, -32768, -32768, 65535, 65535,
                                     'hA5A5, 1'b0));

        // directed: clip running off the screen, single buffer
        next_phase();
        configure(300, 200, 320, 240, 1'b0);
        cmd_queue.push_back(make_req(crff_pkg::CMD_FILL_RECT, 0, 0, 400, 300, 'h5555, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_READ, 310, 220, 0, 0, 0, 1'b1));
        cmd_queue.push_back(make_req(crff_pkg::CMD_SWAP, 0, 0, 0, 0, 0, 1'b0));
        cmd_queue.push_back(make_req(crff_pkg::CMD_HLINE, 0, 199, 320, 0, 'h6666, 1'b0));

        next_phase();
        configure(0, 0, 320, 240, 1'b1);
        random_phase(120, 0, 0, 1'b1, 1'b0, 1'b0);

        next_phase();
        configure(int'($urandom_range(320)), int'($urandom_range(240)),
                  int'($urandom_range(320)), int'($urandom_range(240)), 1'b1);
        random_phase(120, 59, 0, 1'b0, 1'b1, 1'b1);

        next_phase();
        configure(0, 0, 320, 240, 1'b0);
        random_phase(110, 0, 59, 1'b0, 1'b0, 1'b0);

        // empty clip rectangle at the far corner
        next_phase();
        configure(320, 240, 0, 0, 1'b1);
        random_phase(90, 30, 30, 1'b0, 1'b0, 1'b0);

        next_phase();
        configure(int'($urandom_range(320)), int'($urandom_range(240)),
                  int'($urandom_range(320)), int'($urandom_range(240)), 1'b1);
        random_phase(120, 30, 30, 1'b1, 1'b0, 1'b0);

        wait_drained();
        repeat (40) @(posedge clk);
        $display("%0d requests (%0d fills and lines, %0d clears, %0d swaps, %0d reads)",
                 n_accepted, n_fills, n_clears, n_swaps, n_reads);
        $display("%0d responses checked over seven clip settings, %0d mismatches",
                 n_checked, mismatches);
        if (mismatches == 0) begin
            $display("tb_clipped_rect_fill_framebuffer OK");
        end else begin
            $display("tb_clipped_rect_fill_framebuffer NOT OK");
        end
        $finish;
    end

endmodule
